// ===== hdl/rfi_pkg.sv =====
// ----------------------------------------------------------------------------
// rfi_pkg
// Shared types, constants and helpers for the redundancy fault isolator.
// ----------------------------------------------------------------------------
package rfi_pkg;

   localparam int NumNodes = 4;
   localparam int NumPairs = 6;

   // configuration register indexes
   localparam logic CsrLocalIsMain = 1'b0;
   localparam logic CsrTimeout     = 1'b1;

   localparam logic        ResetLocalIsMain = 1'b1;
   localparam logic [15:0] ResetTimeout     = 16'd1000;

   localparam logic [16:0] TickMax = 17'h1FFFF;

   // result kinds
   localparam logic KindStatus  = 1'b0;
   localparam logic KindTimeout = 1'b1;

   // election states
   localparam logic [7:0] StInit       = 8'd0;
   localparam logic [7:0] StElectable  = 8'd1;
   localparam logic [7:0] StInElection = 8'd3;
   localparam logic [7:0] StCompleted  = 8'd4;
   localparam logic [7:0] StUnclosed   = 8'd5;
   localparam logic [7:0] StNoPath     = 8'd6;
   localparam logic [7:0] StSelfStop   = 8'd7;

   // switcher signal codes {failed, self_stopped, usable}
   localparam logic [2:0] SigUsable  = 3'b001;
   localparam logic [2:0] SigStopped = 3'b010;
   localparam logic [2:0] SigFailed  = 3'b100;
   localparam logic [2:0] SigNone    = 3'b000;

   // link pairs: mE-sE, mE-mV, mE-sV, sE-mV, sE-sV, mV-sV
   localparam logic [1:0] PairA [NumPairs] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PairB [NumPairs] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   typedef struct packed {
      logic [3:0] node_bad;
      logic [5:0] pair_bad;
   } fault_type;

   typedef struct packed {
      logic [7:0]  elect_state;
      logic [7:0]  unit_mask;
      logic [15:0] link_matrix;
      logic        system_ready;
   } status_type;

   function automatic logic link_conn(input logic [15:0] m, input logic [1:0] s,
                                      input logic [1:0] d);
      return m[{s, d}];
   endfunction

   function automatic logic [2:0] decode_signals(input logic [7:0] ns);
      logic [2:0] sig;
      case (ns)
         StElectable, StCompleted: sig = SigUsable;
         StSelfStop:               sig = SigStopped;
         StUnclosed, StNoPath:     sig = SigFailed;
         default:                  sig = SigNone;
      endcase
      return sig;
   endfunction

endpackage

// ===== hdl/rfi_fault_judge.sv =====
// ----------------------------------------------------------------------------
// rfi_fault_judge
// Node and link-pair fault derivation from one reported link matrix.
// ----------------------------------------------------------------------------
module rfi_fault_judge
   import rfi_pkg::*;
(
   input  logic        local_is_main,
   input  status_type  status,
   output fault_type   faults
);

   logic [1:0] loc;
   logic [3:0] reach;
   logic [3:0] nf;
   logic [5:0] lf;
   logic       isolated;
   logic       quiet;

   assign loc = local_is_main ? 2'd0 : 2'd1;

   // reports from peers the local node cannot reach are not trusted
   always_comb begin
      for (int p = 0; p < NumNodes; p++) begin
         reach[p] = (2'(p) == loc) ? 1'b1 : link_conn(status.link_matrix, loc, 2'(p));
      end
   end

   assign isolated = !link_conn(status.link_matrix, loc, loc + 2'd1) &&
                     !link_conn(status.link_matrix, loc, loc + 2'd2) &&
                     !link_conn(status.link_matrix, loc, loc + 2'd3);

   assign quiet = (status.elect_state == StInit) || (status.elect_state == StInElection) ||
                  !status.system_ready;

   always_comb begin
      for (int d = 0; d < NumNodes; d++) begin
         nf[d] = 1'b1;
         for (int s = 0; s < NumNodes; s++) begin
            if (s != d && reach[s] && link_conn(status.link_matrix, 2'(s), 2'(d)))
               nf[d] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NumPairs; k++) begin
         lf[k] = !nf[PairA[k]] && !nf[PairB[k]] &&
                 ((reach[PairA[k]] && !link_conn(status.link_matrix, PairA[k], PairB[k])) ||
                  (reach[PairB[k]] && !link_conn(status.link_matrix, PairB[k], PairA[k])));
      end
   end

   always_comb begin
      if (quiet) begin
         faults = '0;
      end else if (isolated) begin
         faults.node_bad = 4'b0001 << loc;
         faults.pair_bad = '0;
      end else begin
         faults.node_bad = nf;
         faults.pair_bad = lf;
      end
   end

endmodule

// ===== hdl/rfi_tick_timer.sv =====
// ----------------------------------------------------------------------------
// rfi_tick_timer
// Counts millisecond ticks since the last status report and flags timeout.
// ----------------------------------------------------------------------------
module rfi_tick_timer
   import rfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        is_tick,
   input  logic [15:0] timeout,
   output logic        timeout_hit
);

   logic        have_status_ff, have_status_in;
   logic [16:0] ticks_ff, ticks_in;
   logic [16:0] ticks_inc;

   assign ticks_inc   = (ticks_ff < TickMax) ? ticks_ff + 17'd1 : ticks_ff;
   assign timeout_hit = is_tick && have_status_ff && (ticks_inc > {1'b0, timeout});

   always_comb begin
      have_status_in = have_status_ff;
      ticks_in       = ticks_ff;
      if (step) begin
         if (!is_tick) begin
            have_status_in = 1'b1;
            ticks_in       = '0;
         end else if (have_status_ff) begin
            ticks_in = ticks_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_status_ff <= 1'b0;
         ticks_ff       <= '0;
      end else begin
         have_status_ff <= have_status_in;
         ticks_ff       <= ticks_in;
      end
   end

endmodule

// ===== hdl/redundancy_fault_isolator.sv =====
// ----------------------------------------------------------------------------
// redundancy_fault_isolator
// Status-report fault isolation for a four-node redundant control system.
// ----------------------------------------------------------------------------
// Channels: req_* carries status reports (req_tuser 0) and millisecond ticks
// (req_tuser 1). rsp_* carries one result per status report and one timeout
// result per tick once the time since the last report exceeds the timeout.
// csr_* writes local_is_main (index 0) and status_timeout_ticks (index 1).
// Path: an accepted transfer is registered in the input register, evaluated
// by the fault logic and registered in the result register that drives rsp_*.
// Throughput: one transfer per cycle while rsp_* is not stalled; the input
// register, the fault logic and the result register form a two-deep pipeline.
// Stall: while rsp_tvalid is high and rsp_tready low, the result holds and
// one more transfer can wait in the input register; then req_tready drops.
// Ticks that give no result leave the output register empty, but still wait
// while it holds a stalled result.
// Reset: synchronous, active high; clears both stages, the tick counter and
// the report-seen flag, and loads local_is_main 1 and a timeout of 1000.
// ----------------------------------------------------------------------------
module redundancy_fault_isolator
   import rfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] election state, [15:8] active mask, [31:16] link_matrix,
   // [32] system_ready, [39:33] zero
   input  logic [39:0] req_tdata,
   // [0] req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] signal_usable, [1] signal_self_stopped, [2] signal_failed,
   // [6:3] active_units, [10:7] node fault bits, [16:11] pair fault bits,
   // [23:17] zero
   output logic [23:0] rsp_tdata,
   // [0] result_kind
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic        local_is_main_ff;
   logic [15:0] timeout_ff;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_tick_ff;
   status_type  s1_status_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [23:0] rsp_data_ff;

   logic        out_free;
   logic        s1_fire;
   logic        timeout_hit;
   logic        has_result;
   logic [2:0]  sig;
   fault_type   faults;
   logic [23:0] rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_is_main_ff <= ResetLocalIsMain;
         timeout_ff       <= ResetTimeout;
      end else if (csr_we) begin
         case (csr_addr)
            CsrLocalIsMain: local_is_main_ff <= csr_wdata[0];
            CsrTimeout:     timeout_ff       <= csr_wdata;
            default:        ;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_tick_ff                <= req_tuser;
         s1_status_ff.elect_state  <= req_tdata[7:0];
         s1_status_ff.unit_mask    <= req_tdata[15:8];
         s1_status_ff.link_matrix  <= req_tdata[31:16];
         s1_status_ff.system_ready <= req_tdata[32];
      end
   end

   rfi_tick_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_fire),
      .is_tick     (s1_tick_ff),
      .timeout     (timeout_ff),
      .timeout_hit (timeout_hit)
   );

   rfi_fault_judge u_judge (
      .local_is_main (local_is_main_ff),
      .status        (s1_status_ff),
      .faults        (faults)
   );

   assign sig        = decode_signals(s1_status_ff.elect_state);
   assign has_result = !s1_tick_ff || timeout_hit;

   always_comb begin
      if (s1_tick_ff)
         rsp_data_in = {7'd0, 6'd0, 4'd0, 4'd0, SigFailed};
      else
         rsp_data_in = {7'd0, faults.pair_bad, faults.node_bad,
                        s1_status_ff.unit_mask[3:0], sig};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire)
         rsp_valid_in = has_result;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_result) begin
         rsp_kind_ff <= s1_tick_ff ? KindTimeout : KindStatus;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ===== tb/redundancy_fault_isolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundancy_fault_isolator_tb
// Stream-level test of the redundancy fault isolator. Status reports and
// millisecond ticks go in on req_*, and a local predictor of the fault logic
// and tick counter queues the results to expect. Each result taken from
// rsp_* is checked against the oldest one. Both sides idle and stall at
// random, and the configuration is changed only between phases.
// ----------------------------------------------------------------------------
module redundancy_fault_isolator_tb;
   import rfi_pkg::*;

   localparam logic ReqStatus = 1'b0;
   localparam logic ReqTick   = 1'b1;
   localparam int   RandomPhases   = 8;
   localparam int   ItemsPerPhase  = 112;

   typedef struct packed {
      logic       kind;
      logic       failed;
      logic       stopped;
      logic       usable;
      logic [3:0] units;
      logic [3:0] node_f;
      logic [5:0] link_f;
   } isolation_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [7:0] election state, [15:8] active mask, [31:16] link_matrix,
   // [32] system_ready, [39:33] zero
   logic [39:0] req_tdata = '0;
   // [0] req_type
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] usable, [1] self_stopped, [2] failed, [6:3] active_units,
   // [10:7] node fault bits, [16:11] pair fault bits, [23:17] zero
   logic [23:0] rsp_tdata;
   // [0] result_kind
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [15:0] csr_wdata = '0;

   // predictor state
   logic        cfg_local_main = ResetLocalIsMain;
   logic [15:0] cfg_timeout = ResetTimeout;
   logic        seen_report = 1'b0;
   logic [16:0] ticks_idle = '0;

   isolation_type pending_results[$];
   int            mismatches = 0;
   bit            steady = 1'b0;
   int            rsp_stall = 0;
   isolation_type rsp_seen, rsp_want;

   redundancy_fault_isolator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(13, 40);
   endfunction

   // node and link-pair faults as seen from the local node
   function automatic void judge_faults(input logic [7:0] ns, input logic [15:0] lm,
                                        input logic rdy, output logic [3:0] nf,
                                        output logic [5:0] lf);
      int  loc, s, d, k, a, b;
      bit  trusted [4][4];
      bit  reach, lost;
      nf = '0;
      lf = '0;
      if (ns == StInit || ns == StInElection || !rdy) return;
      loc = cfg_local_main ? 0 : 1;
      reach = 1'b0;
      for (s = 0; s < NumNodes; s++)
         if (s != loc && lm[loc * 4 + s]) reach = 1'b1;
      if (!reach) begin
         nf[loc] = 1'b1;
         return;
      end
      // reports from peers we cannot reach are not trusted
      for (s = 0; s < NumNodes; s++)
         for (d = 0; d < NumNodes; d++)
            trusted[s][d] = (s == loc) || lm[loc * 4 + s];
      for (d = 0; d < NumNodes; d++) begin
         lost = 1'b1;
         for (s = 0; s < NumNodes; s++)
            if (s != d && trusted[s][d] && lm[s * 4 + d]) lost = 1'b0;
         nf[d] = lost;
      end
      for (k = 0; k < NumPairs; k++) begin
         a = PairA[k];
         b = PairB[k];
         if (!nf[a] && !nf[b] && ((trusted[a][b] && !lm[a * 4 + b]) ||
                                  (trusted[b][a] && !lm[b * 4 + a])))
            lf[k] = 1'b1;
      end
   endfunction

   task automatic predict_transfer(input logic kind, input logic [39:0] data);
      isolation_type r;
      logic [7:0] ns;
      r  = '0;
      ns = data[7:0];
      if (kind == ReqTick) begin
         if (!seen_report) return;
         if (ticks_idle != TickMax) ticks_idle = ticks_idle + 1'b1;
         if (ticks_idle <= {1'b0, cfg_timeout}) return;
         r.kind   = KindTimeout;
         r.failed = 1'b1;
      end else begin
         seen_report = 1'b1;
         ticks_idle  = '0;
         r.kind = KindStatus;
         case (ns)
            StElectable, StCompleted: r.usable  = 1'b1;
            StSelfStop:               r.stopped = 1'b1;
            StUnclosed, StNoPath:     r.failed  = 1'b1;
            default: ;
         endcase
         r.units = data[11:8];
         judge_faults(ns, data[31:16], data[32], r.node_f, r.link_f);
      end
      pending_results = {pending_results, r};
   endtask

   // leaves req_tvalid high after the transfer; the next send replaces or lowers it, settle lowers it
   task automatic send_req(input logic kind, input logic [7:0] ns, input logic [7:0] an,
                           input logic [15:0] lm, input logic rdy);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, rdy, lm, an, ns};
      do @(posedge clock); while (!req_tready);
      predict_transfer(kind, {7'd0, rdy, lm, an, ns});
   endtask

   task automatic send_tick();
      send_req(ReqTick, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   task automatic send_report(input logic [7:0] ns, input logic [7:0] an,
                              input logic [15:0] lm, input logic rdy);
      send_req(ReqStatus, ns, an, lm, rdy);
   endtask

   // drain: nothing in flight, plus pipeline depth for ticks that give no result
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [15:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CsrLocalIsMain) cfg_local_main = value[0];
      else cfg_timeout = value;
   endtask

   task automatic test_tick_before_report();
      repeat (3) send_tick();
      settle();
   endtask

   // reset timeout of 1000 ticks
   task automatic test_default_timeout();
      send_report(StCompleted, 8'h0F, 16'hFFFF, 1'b1);
      repeat (1002) send_tick();
      settle();
   endtask

   task automatic test_signal_decode();
      logic [7:0] states [10];
      int i;
      states = '{StInit, StElectable, 8'd2, StInElection, StCompleted, StUnclosed,
                 StNoPath, StSelfStop, 8'd8, 8'hFF};
      for (i = 0; i < 10; i++)
         send_report(states[i], i[0] ? 8'hFF : 8'h00, 16'hFFFF, 1'b1);
      send_report(StCompleted, 8'hA5, 16'h0000, 1'b0);
      settle();
   endtask

   task automatic test_fault_isolation();
      // local main ECU
      send_report(StCompleted, 8'h0F, 16'h0000, 1'b1);
      send_report(StCompleted, 8'h0F, 16'h0001, 1'b1);   // diagonal only
      send_report(StElectable, 8'h0F, 16'hFFF1, 1'b1);   // local links lost
      send_report(StCompleted, 8'h0F, 16'hFFFF, 1'b1);
      send_report(StCompleted, 8'h0F, 16'h7777, 1'b1);   // sub VCU unreachable
      send_report(StCompleted, 8'h0F, 16'hFFFB, 1'b1);   // mE cannot reach mV
      send_report(StUnclosed,  8'h0F, 16'hFDFF, 1'b1);   // one broken direction
      send_report(8'd2,        8'h0F, 16'h0FFF, 1'b1);
      send_report(StInElection, 8'h0F, 16'h0000, 1'b1);
      send_report(StCompleted, 8'h0F, 16'h0000, 1'b0);
      write_reg(CsrLocalIsMain, 16'd0);
      send_report(StCompleted, 8'h0F, 16'h0020, 1'b1);   // sub ECU isolated
      send_report(StCompleted, 8'h0F, 16'hFF2F, 1'b1);
      send_report(StCompleted, 8'h0F, 16'hFFFF, 1'b1);
      send_report(StNoPath,    8'h0F, 16'hF0FF & 16'hFFBF, 1'b1);
      send_report(StCompleted, 8'h0F, 16'h8FFE, 1'b1);
      settle();
   endtask

   task automatic test_timeout_edges();
      write_reg(CsrTimeout, 16'd0);
      send_report(StElectable, 8'h03, 16'hFFFF, 1'b1);
      repeat (2) send_tick();
      write_reg(CsrTimeout, 16'd3);
      send_report(StElectable, 8'h03, 16'hFFFF, 1'b1);
      repeat (5) send_tick();
      send_report(StSelfStop, 8'h03, 16'hFFFF, 1'b1);
      repeat (4) send_tick();
      settle();
   endtask

   task automatic random_report();
      logic [7:0]  ns;
      logic [15:0] lm;
      int          loc, n;
      loc = cfg_local_main ? 0 : 1;
      ns  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      case ($urandom_range(0, 5))
         0: lm = 16'($urandom);
         1: lm = 16'hFFFF;
         2, 3: begin
            lm = 16'hFFFF;
            repeat ($urandom_range(1, 3)) lm[$urandom_range(0, 15)] = 1'b0;
         end
         4: lm = 16'($urandom) & ~(16'hF << (loc * 4));
         default: begin
            n  = $urandom_range(0, 3);
            lm = 16'hFFFF & ~(($urandom_range(0, 1) ? 16'h1111 : 16'h000F) << (n * 4));
            if ($urandom_range(0, 1)) lm[$urandom_range(0, 15)] = 1'b0;
         end
      endcase
      send_report(ns, 8'($urandom), lm, $urandom_range(0, 9) != 0);
   endtask

   task automatic test_random_traffic();
      int phase, count, burst;
      for (phase = 0; phase < RandomPhases; phase++) begin
         write_reg(CsrLocalIsMain, 16'($urandom_range(0, 1)));
         case ($urandom_range(0, 4))
            0: write_reg(CsrTimeout, 16'd0);
            1, 2: write_reg(CsrTimeout, 16'($urandom_range(1, 4)));
            3: write_reg(CsrTimeout, 16'($urandom_range(5, 30)));
            default: write_reg(CsrTimeout, 16'($urandom));
         endcase
         steady = (phase == 3);
         count = 0;
         while (count < ItemsPerPhase) begin
            if ($urandom_range(0, 2) == 0) begin
               random_report();
               count++;
            end else begin
               burst = $urandom_range(1, 10);
               repeat (burst) send_tick();
               count += burst;
            end
         end
         steady = 1'b0;
      end
      settle();
   endtask

   // result sink: random backpressure
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_tready <= 1'b1;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = {rsp_tuser, rsp_tdata[2], rsp_tdata[1], rsp_tdata[0],
                     rsp_tdata[6:3], rsp_tdata[10:7], rsp_tdata[16:11]};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: kind %0b sig %b%b%b units %h nf %h lf %h",
                        rsp_seen.kind, rsp_seen.failed, rsp_seen.stopped,
                        rsp_seen.usable, rsp_seen.units, rsp_seen.node_f,
                        rsp_seen.link_f);
         end else begin
            rsp_want = pending_results.pop_front();
            if (rsp_seen !== rsp_want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: kind %0b/%0b failed %0b/%0b stopped %0b/%0b ",
                            "usable %0b/%0b units %h/%h nf %h/%h lf %h/%h (exp/act)"},
                           rsp_want.kind, rsp_seen.kind, rsp_want.failed, rsp_seen.failed,
                           rsp_want.stopped, rsp_seen.stopped, rsp_want.usable,
                           rsp_seen.usable, rsp_want.units, rsp_seen.units,
                           rsp_want.node_f, rsp_seen.node_f, rsp_want.link_f,
                           rsp_seen.link_f);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_tick_before_report();
      test_default_timeout();
      test_signal_decode();
      test_fault_isolation();
      test_timeout_edges();
      test_random_traffic();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
